/* rtl/frm_pkg.sv */
// ----------------------------------------------------------------------------
// Frame rate meter package
// Shared widths and constants for the frame rate meter and its checker.
// ----------------------------------------------------------------------------
package frm_pkg;

    localparam int DELAY_W        = 16;
    localparam int RATE_W         = 18;
    localparam int RATE_SCALE     = 256000;
    localparam int WINDOW_DEFAULT = 16;

endpackage

/* rtl/frame_rate_meter.sv */
// ----------------------------------------------------------------------------
// Frame rate meter
// Moving-average frame rate from a stream of inter-frame delays.
// ----------------------------------------------------------------------------
// Each delay transfer with a nonzero delay_ms produces one result. A zero
// delay is dropped with no result. One shared radix-2 restoring divider
// computes the instantaneous rate and then the average rate, one quotient bit
// per cycle. Before the divisions, the S_UPDATE state updates the running sum,
// using the oldest delay that the ring memory reads during the transfer
// itself, and after them the S_OUTPUT state loads the output register. The
// block stalls its input while an item is in progress. A finished result
// waits in an output register so that the next delay can already be taken;
// while that register still holds an untaken result, the next finished result
// and the input both wait. Both rates are unsigned with 8 fraction bits,
// truncated. No clearing pass is needed after reset.
module frame_rate_meter #(
    parameter int WINDOW = frm_pkg::WINDOW_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       delay_valid,
    output logic                       delay_stall,
    input  logic [frm_pkg::DELAY_W-1:0] delay_ms,
    output logic                       rate_valid,
    input  logic                       rate_stall,
    output logic [frm_pkg::RATE_W-1:0]  instant_rate,
    output logic [frm_pkg::RATE_W-1:0]  average_rate,
    output logic                       window_full
);

    import frm_pkg::*;

    localparam int POS_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = DELAY_W + CNT_W;
    localparam int NUM_W  = RATE_W + CNT_W;
    localparam int STEP_W = $clog2(NUM_W);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_UPDATE   = 5'b00010,
        S_DIV_INST = 5'b00100,
        S_DIV_AVG  = 5'b01000,
        S_OUTPUT   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                filled_reg, filled_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                rate_valid_reg, rate_valid_next;

    logic [DELAY_W-1:0]  delay_reg, delay_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [SUM_W-1:0]    den_reg, den_next;
    logic [SUM_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]    avg_num_reg, avg_num_next;
    logic [RATE_W-1:0]   inst_reg, inst_next;
    logic [RATE_W-1:0]   inst_out_reg, inst_out_next;
    logic [RATE_W-1:0]   avg_out_reg, avg_out_next;
    logic                full_out_reg, full_out_next;

    logic                in_xfer;
    logic                ram_wr_en;
    logic [DELAY_W-1:0]  ram_rd_data;
    logic [DELAY_W-1:0]  old_delay;
    logic [POS_W-1:0]    pos_inc;
    logic                pos_wrap;
    logic [CNT_W-1:0]    count;
    logic [SUM_W:0]      trial;
    logic                trial_ge;
    logic [SUM_W-1:0]    step_rem;
    logic [NUM_W-1:0]    step_quo;
    logic                step_last;
    logic                out_free;

    assign delay_stall  = (state_reg != S_IDLE);
    assign in_xfer      = delay_valid && !delay_stall;
    assign ram_wr_en    = (state_reg == S_UPDATE);
    assign rate_valid   = rate_valid_reg;
    assign instant_rate = inst_out_reg;
    assign average_rate = avg_out_reg;
    assign window_full  = full_out_reg;

    frm_ram #(
        .WIDTH (DELAY_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (delay_reg),
        .rd_en   (in_xfer),
        .rd_addr (pos_reg),
        .rd_data (ram_rd_data)
    );

    // Until the ring has wrapped, the entry at the write position was never
    // written and counts as zero.
    assign old_delay = filled_reg ? ram_rd_data : '0;
    assign pos_wrap  = (pos_reg == POS_W'(WINDOW - 1));
    assign pos_inc   = pos_wrap ? '0 : pos_reg + 1'b1;
    assign count     = (filled_reg || pos_wrap) ? CNT_W'(WINDOW) : CNT_W'(pos_inc);

    // One restoring division step.
    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge  = (trial >= {1'b0, den_reg});
    assign step_rem  = trial_ge ? SUM_W'(trial - {1'b0, den_reg}) : SUM_W'(trial);
    assign step_quo  = {num_reg[NUM_W-2:0], trial_ge};
    assign step_last = (step_reg == '0);
    assign out_free  = !rate_valid_reg || !rate_stall;

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        filled_next     = filled_reg;
        step_next       = step_reg;
        rate_valid_next = rate_valid_reg && rate_stall;
        delay_next      = delay_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        avg_num_next    = avg_num_reg;
        inst_next       = inst_reg;
        inst_out_next   = inst_out_reg;
        avg_out_next    = avg_out_reg;
        full_out_next   = full_out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (delay_ms != '0))
                begin
                    delay_next = delay_ms;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                sum_next     = sum_reg - SUM_W'(old_delay) + SUM_W'(delay_reg);
                pos_next     = pos_inc;
                filled_next  = filled_reg || pos_wrap;
                avg_num_next = NUM_W'(RATE_SCALE) * NUM_W'(count);
                num_next     = NUM_W'(RATE_SCALE);
                den_next     = SUM_W'(delay_reg);
                rem_next     = '0;
                step_next    = STEP_W'(NUM_W - 1);
                state_next   = S_DIV_INST;
            end
            S_DIV_INST:
            begin
                num_next  = step_quo;
                rem_next  = step_rem;
                step_next = step_reg - 1'b1;
                if (step_last)
                begin
                    inst_next  = step_quo[RATE_W-1:0];
                    num_next   = avg_num_reg;
                    den_next   = sum_reg;
                    rem_next   = '0;
                    step_next  = STEP_W'(NUM_W - 1);
                    state_next = S_DIV_AVG;
                end
            end
            S_DIV_AVG:
            begin
                num_next  = step_quo;
                rem_next  = step_rem;
                step_next = step_reg - 1'b1;
                if (step_last)
                begin
                    state_next = S_OUTPUT;
                end
            end
            S_OUTPUT:
            begin
                if (out_free)
                begin
                    rate_valid_next = 1'b1;
                    inst_out_next   = inst_reg;
                    avg_out_next    = num_reg[RATE_W-1:0];
                    full_out_next   = filled_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            sum_reg        <= '0;
            filled_reg     <= 1'b0;
            step_reg       <= '0;
            rate_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            filled_reg     <= filled_next;
            step_reg       <= step_next;
            rate_valid_reg <= rate_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delay_reg    <= delay_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        avg_num_reg  <= avg_num_next;
        inst_reg     <= inst_next;
        inst_out_reg <= inst_out_next;
        avg_out_reg  <= avg_out_next;
        full_out_reg <= full_out_next;
    end

endmodule

/* rtl/frm_ram.sv */
// ----------------------------------------------------------------------------
// Frame rate meter RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module frm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/frm_checker.sv */
// ----------------------------------------------------------------------------
// Frame rate meter checker
// Port-level assertions on the frame rate meter, attached by bind.
// ----------------------------------------------------------------------------
module frm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       delay_valid,
    input logic                       delay_stall,
    input logic [frm_pkg::DELAY_W-1:0] delay_ms,
    input logic                       rate_valid,
    input logic                       rate_stall,
    input logic [frm_pkg::RATE_W-1:0]  instant_rate,
    input logic [frm_pkg::RATE_W-1:0]  average_rate,
    input logic                       window_full
);

    import frm_pkg::*;

    logic full_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_seen_reg <= 1'b0;
        end
        else if (rate_valid && !rate_stall && window_full)
        begin
            full_seen_reg <= 1'b1;
        end
    end

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rate_valid && rate_stall |=> rate_valid && $stable(instant_rate)
            && $stable(average_rate) && $stable(window_full))
    else $error("stalled result changed");

    // A nonzero delay keeps the input stalled on the next cycle while it is divided.
    assert property (@(posedge clk) disable iff (!rst_n)
        delay_valid && !delay_stall && (delay_ms != '0) |=> delay_stall)
    else $error("input not stalled after nonzero delay transfer");

    // Once a full window is reported, every later result reports it too.
    assert property (@(posedge clk) disable iff (!rst_n)
        rate_valid && full_seen_reg |-> window_full)
    else $error("window_full dropped after being reported");

    // Rates stay within the range set by a 16-bit delay.
    assert property (@(posedge clk) disable iff (!rst_n)
        rate_valid |-> (instant_rate >= RATE_W'(3))
            && (instant_rate <= RATE_W'(RATE_SCALE))
            && (average_rate <= RATE_W'(RATE_SCALE)))
    else $error("rate out of range");

endmodule

bind frame_rate_meter frm_checker u_frm_checker (.*);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Frame rate meter testbench
// Drives inter-frame delays into the meter, including zero delays that must
// be dropped, and checks every instantaneous and average rate, all but two
// against an internal model of the delay ring. A short list of directed
// delays comes first, followed by random traffic with random gaps and stalls
// on both sides and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb;

    import frm_pkg::*;

    localparam int WINDOW       = WINDOW_DEFAULT;
    localparam int NUM_DIRECTED = 23;
    localparam int NUM_RANDOM   = 1000;
    localparam int LONG_HOLD    = 600;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [RATE_W-1:0] instant;
        logic [RATE_W-1:0] average;
        logic              full;
    } rate_t;

    typedef struct {
        logic [DELAY_W-1:0] delay;
        bit                 typed;
        rate_t              rates;
    } delay_row_t;

    logic                clk;
    logic                rst_n;
    logic                delay_valid;
    logic                delay_stall;
    logic [DELAY_W-1:0]  delay_ms;
    logic                rate_valid;
    logic                rate_stall;
    logic [RATE_W-1:0]   instant_rate;
    logic [RATE_W-1:0]   average_rate;
    logic                window_full;

    logic [DELAY_W-1:0]  meter_ring [WINDOW];
    int unsigned         meter_pos;
    longint unsigned     meter_sum;
    bit                  meter_filled;

    rate_t               rate_queue [$];
    int                  mismatches;
    int                  results_checked;
    int                  delays_sent;
    int                  zeros_sent;
    int                  window_wraps;
    bit                  sender_idles;
    bit                  sink_idles;
    bit                  long_hold_done;

    delay_row_t directed_rows [NUM_DIRECTED] = '{
        '{16'd0,     1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'd1,     1'b1, '{18'd256000, 18'd256000, 1'b0}},
        '{16'd65535, 1'b1, '{18'd3,      18'd7,      1'b0}},
        '{16'd0,     1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'd1000,  1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'h5555,  1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'hAAAA,  1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'h8000,  1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'h7FFF,  1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'd2,     1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'h00FF,  1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'hFF00,  1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'd40,    1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'd33,    1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'd17,    1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'd0,     1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'd3,     1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'h0F0F,  1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'hF0F0,  1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'd65535, 1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'd1,     1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'd0,     1'b0, '{18'd0,      18'd0,      1'b0}},
        '{16'd5,     1'b0, '{18'd0,      18'd0,      1'b0}}
    };

    frame_rate_meter #(
        .WINDOW(WINDOW)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .delay_valid  (delay_valid),
        .delay_stall  (delay_stall),
        .delay_ms     (delay_ms),
        .rate_valid   (rate_valid),
        .rate_stall   (rate_stall),
        .instant_rate (instant_rate),
        .average_rate (average_rate),
        .window_full  (window_full)
    );

    always #5 clk = ~clk;

    // Updates the delay ring with a nonzero delay and returns its rates; a zero delay is ignored.
    function automatic bit meter_update(input logic [DELAY_W-1:0] d, output rate_t r);
        longint unsigned count;
        r = '{default: '0};
        if (d == 0)
            return 1'b0;
        meter_sum = meter_sum - meter_ring[meter_pos] + d;
        meter_ring[meter_pos] = d;
        if (meter_pos == WINDOW - 1)
        begin
            meter_pos = 0;
            meter_filled = 1'b1;
            window_wraps++;
        end
        else
        begin
            meter_pos++;
        end
        count = meter_filled ? WINDOW : meter_pos;
        r.instant = RATE_W'(longint'(RATE_SCALE) / d);
        r.average = (meter_sum == 0) ? '0 :
                    RATE_W'((longint'(RATE_SCALE) * count) / meter_sum);
        r.full = meter_filled;
        return 1'b1;
    endfunction

    task automatic send_delay(input logic [DELAY_W-1:0] d);
        int gap;
        gap = sender_idles ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            delay_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        delay_valid <= 1'b1;
        delay_ms    <= d;
        @(posedge clk);
        while (delay_stall)
            @(posedge clk);
        if (d == 0)
            zeros_sent++;
        else
            delays_sent++;
    endtask

    function automatic logic [DELAY_W-1:0] random_delay();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return '0;
        else if (pick < 45)
            return DELAY_W'($urandom_range(10, 100));
        else if (pick < 75)
            return DELAY_W'($urandom_range(1, 65535));
        else if (pick < 85)
            return DELAY_W'($urandom_range(1, 9));
        else if (pick < 93)
            return DELAY_W'(1) << $urandom_range(0, DELAY_W - 1);
        else
            return DELAY_W'($urandom_range(65000, 65535));
    endfunction

    initial
    begin : timeout_guard
        #4000000;
        $display("[frame_rate_meter] ERROR");
        $finish;
    end

    initial
    begin : rate_sink
        int    hold;
        rate_t want;
        @(posedge rst_n);
        forever
        begin
            if (results_checked % 100 == 0)
                sink_idles = ($urandom_range(0, 3) != 0);
            hold = sink_idles ? $urandom_range(0, 6) : 0;
            if (results_checked == 200 && !long_hold_done)
            begin
                hold = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            @(negedge clk);
            if (hold > 0)
            begin
                rate_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                rate_stall <= 1'b0;
            end
            @(posedge clk);
            while (!rate_valid)
                @(posedge clk);
            results_checked++;
            if (rate_queue.size() == 0)
            begin
                $display("%0t: unexpected rate transfer, instant %0d average %0d full %0b",
                         $time, instant_rate, average_rate, window_full);
                mismatches++;
            end
            else
            begin
                want = rate_queue.pop_front();
                if (instant_rate !== want.instant)
                begin
                    $display("%0t: instant_rate expected %0d, got %0d",
                             $time, want.instant, instant_rate);
                    mismatches++;
                end
                if (average_rate !== want.average)
                begin
                    $display("%0t: average_rate expected %0d, got %0d",
                             $time, want.average, average_rate);
                    mismatches++;
                end
                if (window_full !== want.full)
                begin
                    $display("%0t: window_full expected %0b, got %0b",
                             $time, want.full, window_full);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : delay_source
        rate_t              pred;
        logic [DELAY_W-1:0] d;
        int                 guard;

        clk          = 1'b0;
        rst_n        = 1'b0;
        delay_valid  = 1'b0;
        delay_ms     = '0;
        rate_stall   = 1'b0;
        meter_pos    = 0;
        meter_sum    = 0;
        meter_filled = 1'b0;
        for (int i = 0; i < WINDOW; i++)
            meter_ring[i] = '0;
        sender_idles = 1'b1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            send_delay(directed_rows[i].delay);
            if (meter_update(directed_rows[i].delay, pred))
                rate_queue.push_back(directed_rows[i].typed ? directed_rows[i].rates : pred);
        end

        while (delays_sent < NUM_DIRECTED - 4 + NUM_RANDOM)
        begin
            if (delays_sent % 128 == 0)
                sender_idles = ($urandom_range(0, 3) != 0);
            d = random_delay();
            send_delay(d);
            if (meter_update(d, pred))
                rate_queue.push_back(pred);
        end

        @(negedge clk);
        delay_valid <= 1'b0;

        guard = 0;
        while (rate_queue.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (rate_queue.size() != 0)
        begin
            $display("%0t: %0d expected rate transfers never arrived", $time, rate_queue.size());
            mismatches++;
        end

        $display("Sent %0d nonzero and %0d zero delays; checked %0d rate transfers.",
                 delays_sent, zeros_sent, results_checked);
        $display("The delay ring wrapped %0d times; %0d mismatches were found.",
                 window_wraps, mismatches);
        if (mismatches == 0)
            $display("[frame_rate_meter] OK");
        else
            $display("[frame_rate_meter] ERROR");
        $finish;
    end

endmodule
